// ===== rtl/hsl_pkg.sv =====
// hsl_pkg: shared types and constants for the HSL to RGB converter.
// No dependencies; imported by hsl_prep, hsl_chan and hsl_to_rgb_converter.
package hsl_pkg;

  localparam int HUE_TURN  = 360;
  localparam int PCT_MAX   = 100;
  localparam int PCT_HALF  = 50;
  localparam int LIT_TWICE = 200;
  localparam int RAMP_STEP = 60;

  // 255/600000 reduces to 17/40000, and 40000 = 64 * 625.
  // floor(y/625) for y < 2^18 is exactly (y * 429497) >> 28.
  localparam int CH_NUM      = 17;
  localparam int CH_SHIFT    = 6;
  localparam int RECIP       = 429497;
  localparam int RECIP_SHIFT = 28;

  localparam int HUE_W  = 9;   // 0..359
  localparam int PCT_W  = 7;   // 0..100
  localparam int MID_W  = 14;  // high, low and their difference, <= 10000
  localparam int FRAC_W = 6;   // ramp position, 0..60
  localparam int RAMP_W = 20;  // ramp value, <= 600000
  localparam int CH_W   = 8;

  localparam int STAGES = 6;

  typedef logic [MID_W-1:0]  mid_t;
  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [CH_W-1:0]   chan_t;

  // per-stage load strobes
  typedef struct packed {
    logic [2:0] prep;
    logic [2:0] chan;
  } hsl_ld_t;

  typedef struct packed {
    mid_t low;
    mid_t diff;
  } hsl_coef_t;

endpackage

// ===== rtl/hsl_to_rgb_converter.sv =====
// hsl_to_rgb_converter: HSL to 8-bit RGB, six-stage pipeline.
// Depends on hsl_pkg, hsl_prep and hsl_chan.
//
//  channel | dir | signals                    | payload
//  --------+-----+----------------------------+-----------------------------------
//  in      | in  | in_tvalid/tready/tdata[31:0] | hue, saturation, lightness
//  out     | out | out_tvalid/tready/tdata[23:0]| red, green, blue
//
// One transaction per clock sustained while out_tready is high; a result passes
// through the six register stages (wrap/clamp, intermediates, ramp positions,
// ramp value, scale, reciprocal multiply) before out_tvalid rises.
// Reset clears only the stage valid bits. Each stage takes new data when it
// is empty or the next stage moves on, so bubbles close up under a stall.
module hsl_to_rgb_converter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [9:0] hue_in, [17:10] saturation_in,
                                  // [25:18] lightness_in, [31:26] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [7:0] red_out, [15:8] green_out, [23:16] blue_out
);
  import hsl_pkg::*;

  logic [STAGES-1:0] vld_r, vld_nxt, vld_in, rdy;
  hsl_ld_t           ld;
  hsl_coef_t         coef;
  frac_t             f_red, f_green, f_blue;
  chan_t             red_out, green_out, blue_out;

  always_comb begin
    vld_in = {vld_r[STAGES-2:0], in_tvalid};
    rdy[STAGES-1] = ~vld_r[STAGES-1] | out_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      rdy[k] = ~vld_r[k] | rdy[k+1];
    end
    for (int k = 0; k < STAGES; k++) begin
      vld_nxt[k] = rdy[k] ? vld_in[k] : vld_r[k];
    end
    ld.prep = rdy[2:0] & vld_in[2:0];
    ld.chan = rdy[5:3] & vld_in[5:3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  hsl_prep u_prep (
    .clk           (clk),
    .ld            (ld.prep),
    .hue_in        (in_tdata[9:0]),
    .saturation_in (in_tdata[17:10]),
    .lightness_in  (in_tdata[25:18]),
    .coef          (coef),
    .f_red         (f_red),
    .f_green       (f_green),
    .f_blue        (f_blue)
  );

  hsl_chan u_red (
    .clk      (clk),
    .ld       (ld.chan),
    .coef     (coef),
    .frac     (f_red),
    .chan_out (red_out)
  );

  hsl_chan u_green (
    .clk      (clk),
    .ld       (ld.chan),
    .coef     (coef),
    .frac     (f_green),
    .chan_out (green_out)
  );

  hsl_chan u_blue (
    .clk      (clk),
    .ld       (ld.chan),
    .coef     (coef),
    .frac     (f_blue),
    .chan_out (blue_out)
  );

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = {blue_out, green_out, red_out};

endmodule

// ===== rtl/hsl_prep.sv =====
// hsl_prep: first three pipeline stages - hue wrap, clamping, high/low
// intermediates and ramp positions per channel. Depends on hsl_pkg.
module hsl_prep (
  input  logic                clk,
  input  logic [2:0]          ld,
  input  logic [9:0]          hue_in,
  input  logic [7:0]          saturation_in,
  input  logic [7:0]          lightness_in,
  output hsl_pkg::hsl_coef_t  coef,
  output hsl_pkg::frac_t      f_red,
  output hsl_pkg::frac_t      f_green,
  output hsl_pkg::frac_t      f_blue
);
  import hsl_pkg::*;

  // ramp position: rising over 0..59, flat top to 179, falling to 239, floor after
  function automatic frac_t ramp_frac(input logic [HUE_W-1:0] a);
    frac_t f;
    if (a < HUE_W'(RAMP_STEP)) begin
      f = FRAC_W'(a);
    end else if (a < HUE_W'(3 * RAMP_STEP)) begin
      f = FRAC_W'(RAMP_STEP);
    end else if (a < HUE_W'(4 * RAMP_STEP)) begin
      f = FRAC_W'(HUE_W'(4 * RAMP_STEP) - a);
    end else begin
      f = '0;
    end
    return f;
  endfunction

  // stage 0
  logic [HUE_W-1:0] hue_r, hue_nxt;
  logic [PCT_W-1:0] sat_r, sat_nxt, lit_r, lit_nxt;

  always_comb begin
    if (hue_in >= 10'(2 * HUE_TURN)) begin
      hue_nxt = HUE_W'(hue_in - 10'(2 * HUE_TURN));
    end else if (hue_in >= 10'(HUE_TURN)) begin
      hue_nxt = HUE_W'(hue_in - 10'(HUE_TURN));
    end else begin
      hue_nxt = HUE_W'(hue_in);
    end
    sat_nxt = (saturation_in > 8'(PCT_MAX)) ? PCT_W'(PCT_MAX) : saturation_in[PCT_W-1:0];
    lit_nxt = (lightness_in > 8'(PCT_MAX)) ? PCT_W'(PCT_MAX) : lightness_in[PCT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      lit_r <= lit_nxt;
    end
  end

  // stage 1: high intermediate, 200*L and the shifted angles
  // zero saturation needs no path of its own: high = low = 100*L gives the grey
  mid_t             high_r, high_nxt;
  logic [14:0]      lit2_r, lit2_nxt;
  logic [HUE_W-1:0] ang_r_r, ang_r_nxt, ang_g_r, ang_b_r, ang_b_nxt;
  logic [7:0]       sat_sum, ls_sum;
  logic [14:0]      prod_dark, prod_light;

  always_comb begin
    sat_sum    = 8'(PCT_MAX) + {1'b0, sat_r};
    ls_sum     = {1'b0, lit_r} + {1'b0, sat_r};
    prod_dark  = 15'(lit_r) * 15'(sat_sum);
    prod_light = 15'(ls_sum) * 15'(PCT_MAX) - 15'(sat_r) * 15'(lit_r);
    high_nxt   = (lit_r < PCT_W'(PCT_HALF)) ? prod_dark[MID_W-1:0] : prod_light[MID_W-1:0];
    lit2_nxt   = 15'(lit_r) * 15'(LIT_TWICE);
    ang_r_nxt  = (hue_r < HUE_W'(4 * RAMP_STEP)) ? hue_r + HUE_W'(2 * RAMP_STEP)
                                                 : hue_r - HUE_W'(4 * RAMP_STEP);
    ang_b_nxt  = (hue_r >= HUE_W'(2 * RAMP_STEP)) ? hue_r - HUE_W'(2 * RAMP_STEP)
                                                  : hue_r + HUE_W'(4 * RAMP_STEP);
  end

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      high_r  <= high_nxt;
      lit2_r  <= lit2_nxt;
      ang_r_r <= ang_r_nxt;
      ang_g_r <= hue_r;
      ang_b_r <= ang_b_nxt;
    end
  end

  // stage 2: low, spread and ramp positions
  mid_t  low_nxt, diff_nxt;
  hsl_coef_t coef_r;
  frac_t f_red_r, f_green_r, f_blue_r;

  always_comb begin
    low_nxt  = MID_W'(lit2_r - 15'(high_r));
    diff_nxt = high_r - low_nxt;
  end

  always_ff @(posedge clk) begin
    if (ld[2]) begin
      coef_r.low  <= low_nxt;
      coef_r.diff <= diff_nxt;
      f_red_r     <= ramp_frac(ang_r_r);
      f_green_r   <= ramp_frac(ang_g_r);
      f_blue_r    <= ramp_frac(ang_b_r);
    end
  end

  assign coef    = coef_r;
  assign f_red   = f_red_r;
  assign f_green = f_green_r;
  assign f_blue  = f_blue_r;

endmodule

// ===== rtl/hsl_chan.sv =====
// hsl_chan: last three pipeline stages of one colour channel - ramp value,
// then scaling by 255/600000 through a reciprocal multiply. Depends on hsl_pkg.
module hsl_chan (
  input  logic               clk,
  input  logic [2:0]         ld,
  input  hsl_pkg::hsl_coef_t coef,
  input  hsl_pkg::frac_t     frac,
  output hsl_pkg::chan_t     chan_out
);
  import hsl_pkg::*;

  localparam int SC_W = RAMP_W + 5;           // ramp * 17
  localparam int Y_W  = SC_W - CH_SHIFT;      // after the divide by 64
  localparam int P_W  = Y_W + 19;             // times the reciprocal

  logic [RAMP_W-1:0] ramp_r, ramp_nxt;
  logic [SC_W-1:0]   sc;
  logic [Y_W-1:0]    y_r;
  logic [P_W-1:0]    prod;
  chan_t             q_r;

  // low*60 + spread*position covers all four ramp segments
  always_comb begin
    ramp_nxt = RAMP_W'(coef.low) * RAMP_W'(RAMP_STEP) + RAMP_W'(coef.diff) * RAMP_W'(frac);
    sc       = SC_W'(ramp_r) * SC_W'(CH_NUM);
    prod     = P_W'(y_r) * P_W'(RECIP);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      ramp_r <= ramp_nxt;
    end
    if (ld[1]) begin
      y_r <= sc[SC_W-1:CH_SHIFT];
    end
    if (ld[2]) begin
      q_r <= prod[RECIP_SHIFT +: CH_W];
    end
  end

  assign chan_out = q_r;

endmodule
